// File: rtl/core/rbi_pkg.sv
// ----------------------------------------------------------------------------
// rbi_pkg
// shared types, codes and the control store of the rigid body integrator
// ----------------------------------------------------------------------------
package rbi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int PC_W      = 5;

    typedef logic signed [W-1:0] t_word;
    typedef logic [PC_W-1:0]     t_pc;

    typedef enum logic [2:0] {
        CMD_IMPULSE     = 3'd0,
        CMD_ANG_IMPULSE = 3'd1,
        CMD_HALF_STEP   = 3'd2,
        CMD_FULL_STEP   = 3'd3,
        CMD_RESTART     = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_INV_MASS    = 3'd0,
        CFG_INV_INERTIA = 3'd1,
        CFG_IS_STATIC   = 3'd2,
        CFG_START_X     = 3'd3,
        CFG_START_Y     = 3'd4,
        CFG_START_ANGLE = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        SRC_ZERO  = 5'd0,
        SRC_POS_X = 5'd1,
        SRC_POS_Y = 5'd2,
        SRC_VEL_X = 5'd3,
        SRC_VEL_Y = 5'd4,
        SRC_ROT   = 5'd5,
        SRC_SPIN  = 5'd6,
        SRC_TA    = 5'd7,
        SRC_TB    = 5'd8,
        SRC_VX    = 5'd9,
        SRC_VY    = 5'd10,
        SRC_PX    = 5'd11,
        SRC_PY    = 5'd12,
        SRC_SC    = 5'd13,
        SRC_DT    = 5'd14,
        SRC_INV_M = 5'd15,
        SRC_INV_I = 5'd16,
        SRC_ST_X  = 5'd17,
        SRC_ST_Y  = 5'd18,
        SRC_ST_A  = 5'd19,
        SRC_PROD  = 5'd20
    } t_src;

    typedef enum logic [3:0] {
        DST_NONE  = 4'd0,
        DST_POS_X = 4'd1,
        DST_POS_Y = 4'd2,
        DST_VEL_X = 4'd3,
        DST_VEL_Y = 4'd4,
        DST_ROT   = 4'd5,
        DST_SPIN  = 4'd6,
        DST_TA    = 4'd7,
        DST_TB    = 4'd8
    } t_dst;

    typedef enum logic [1:0] {
        COND_NEVER  = 2'd0,
        COND_STATIC = 2'd1,
        COND_HALF   = 2'd2
    } t_cond;

    typedef struct packed {
        t_src  mul_a;
        t_src  mul_b;
        t_src  add_x;
        t_src  add_y;
        logic  sub;
        logic  half;
        t_dst  dst;
        t_cond cond;
        t_pc   target;
        logic  last;
    } t_uword;

    localparam t_pc EP_END      = 5'd0;
    localparam t_pc EP_IMPULSE  = 5'd1;
    localparam t_pc EP_ANG      = 5'd11;
    localparam t_pc EP_STEP     = 5'd13;
    localparam t_pc EP_RESTART  = 5'd21;

    function automatic t_uword uw(t_src a, t_src b, t_src x, t_src y, logic sub,
                                  logic half, t_dst d, t_cond c, t_pc tgt,
                                  logic last);
        t_uword w;
        w.mul_a  = a;
        w.mul_b  = b;
        w.add_x  = x;
        w.add_y  = y;
        w.sub    = sub;
        w.half   = half;
        w.dst    = d;
        w.cond   = c;
        w.target = tgt;
        w.last   = last;
        return w;
    endfunction

    function automatic t_uword ucode(t_pc pc);
        t_uword w;
        unique case (pc)
            // impulse: velocity kicks, lever arm, cross product, spin kick
            5'd1:  w = uw(SRC_VX, SRC_INV_M, SRC_PX, SRC_POS_X, 1'b1, 1'b0, DST_TA,
                          COND_NEVER, EP_END, 1'b0);
            5'd2:  w = uw(SRC_VY, SRC_INV_M, SRC_VEL_X, SRC_PROD, 1'b0, 1'b0, DST_VEL_X,
                          COND_NEVER, EP_END, 1'b0);
            5'd3:  w = uw(SRC_ZERO, SRC_ZERO, SRC_VEL_Y, SRC_PROD, 1'b0, 1'b0, DST_VEL_Y,
                          COND_NEVER, EP_END, 1'b0);
            5'd4:  w = uw(SRC_ZERO, SRC_ZERO, SRC_PY, SRC_POS_Y, 1'b1, 1'b0, DST_TB,
                          COND_NEVER, EP_END, 1'b0);
            5'd5:  w = uw(SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_TB, 1'b1, 1'b0, DST_TB,
                          COND_NEVER, EP_END, 1'b0);
            5'd6:  w = uw(SRC_VX, SRC_TB, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE,
                          COND_NEVER, EP_END, 1'b0);
            5'd7:  w = uw(SRC_VY, SRC_TA, SRC_ZERO, SRC_PROD, 1'b0, 1'b0, DST_TB,
                          COND_NEVER, EP_END, 1'b0);
            5'd8:  w = uw(SRC_ZERO, SRC_ZERO, SRC_TB, SRC_PROD, 1'b0, 1'b0, DST_TB,
                          COND_NEVER, EP_END, 1'b0);
            5'd9:  w = uw(SRC_TB, SRC_INV_I, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE,
                          COND_NEVER, EP_END, 1'b0);
            5'd10: w = uw(SRC_ZERO, SRC_ZERO, SRC_SPIN, SRC_PROD, 1'b0, 1'b0, DST_SPIN,
                          COND_NEVER, EP_END, 1'b1);
            // angular impulse
            5'd11: w = uw(SRC_SC, SRC_INV_I, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE,
                          COND_NEVER, EP_END, 1'b0);
            5'd12: w = uw(SRC_ZERO, SRC_ZERO, SRC_SPIN, SRC_PROD, 1'b0, 1'b0, DST_SPIN,
                          COND_NEVER, EP_END, 1'b1);
            // half kick, then drift for a full step; a half step ends after the kick, a static body skips both
            5'd13: w = uw(SRC_VX, SRC_DT, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE,
                          COND_STATIC, EP_END, 1'b0);
            5'd14: w = uw(SRC_VY, SRC_DT, SRC_VEL_X, SRC_PROD, 1'b0, 1'b1, DST_VEL_X,
                          COND_NEVER, EP_END, 1'b0);
            5'd15: w = uw(SRC_SC, SRC_DT, SRC_VEL_Y, SRC_PROD, 1'b0, 1'b1, DST_VEL_Y,
                          COND_NEVER, EP_END, 1'b0);
            5'd16: w = uw(SRC_ZERO, SRC_ZERO, SRC_SPIN, SRC_PROD, 1'b0, 1'b1, DST_SPIN,
                          COND_HALF, EP_END, 1'b0);
            5'd17: w = uw(SRC_VEL_X, SRC_DT, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE,
                          COND_NEVER, EP_END, 1'b0);
            5'd18: w = uw(SRC_VEL_Y, SRC_DT, SRC_POS_X, SRC_PROD, 1'b0, 1'b0, DST_POS_X,
                          COND_NEVER, EP_END, 1'b0);
            5'd19: w = uw(SRC_SPIN, SRC_DT, SRC_POS_Y, SRC_PROD, 1'b0, 1'b0, DST_POS_Y,
                          COND_NEVER, EP_END, 1'b0);
            5'd20: w = uw(SRC_ZERO, SRC_ZERO, SRC_ROT, SRC_PROD, 1'b0, 1'b0, DST_ROT,
                          COND_NEVER, EP_END, 1'b1);
            // restart at the start pose with zero velocity and spin
            5'd21: w = uw(SRC_ZERO, SRC_ZERO, SRC_ST_X, SRC_ZERO, 1'b0, 1'b0, DST_POS_X,
                          COND_NEVER, EP_END, 1'b0);
            5'd22: w = uw(SRC_ZERO, SRC_ZERO, SRC_ST_Y, SRC_ZERO, 1'b0, 1'b0, DST_POS_Y,
                          COND_NEVER, EP_END, 1'b0);
            5'd23: w = uw(SRC_ZERO, SRC_ZERO, SRC_ST_A, SRC_ZERO, 1'b0, 1'b0, DST_ROT,
                          COND_NEVER, EP_END, 1'b0);
            5'd24: w = uw(SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_VEL_X,
                          COND_NEVER, EP_END, 1'b0);
            5'd25: w = uw(SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_VEL_Y,
                          COND_NEVER, EP_END, 1'b0);
            5'd26: w = uw(SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_SPIN,
                          COND_NEVER, EP_END, 1'b1);
            // end word, also the target of early exits
            default: w = uw(SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO, 1'b0, 1'b0, DST_NONE,
                            COND_NEVER, EP_END, 1'b1);
        endcase
        return w;
    endfunction

    function automatic t_pc entry(logic [2:0] cmd);
        t_pc pc;
        unique case (cmd)
            CMD_IMPULSE:     pc = EP_IMPULSE;
            CMD_ANG_IMPULSE: pc = EP_ANG;
            CMD_HALF_STEP:   pc = EP_STEP;
            CMD_FULL_STEP:   pc = EP_STEP;
            CMD_RESTART:     pc = EP_RESTART;
            default:         pc = EP_END;
        endcase
        return pc;
    endfunction

endpackage

// File: rtl/core/rigid_body_integrator_top.sv
// ----------------------------------------------------------------------------
// rigid_body_integrator_top
// one item at a time: the input stalls until the result beat of the last item
// is registered, while the single shared 32x32 multiplier and saturating adder
// are stepped through the control store for each command
// reset: synchronous active low, clears config, body state and handshakes
// ----------------------------------------------------------------------------
module rigid_body_integrator_top
    import rbi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [W-1:0]        i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_command,
    input  logic signed [W-1:0] i_vec_x,
    input  logic signed [W-1:0] i_vec_y,
    input  logic signed [W-1:0] i_point_x,
    input  logic signed [W-1:0] i_point_y,
    input  logic signed [W-1:0] i_scalar_value,
    input  logic [W-2:0]        i_time_step,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [W-1:0] o_pos_x,
    output logic signed [W-1:0] o_pos_y,
    output logic signed [W-1:0] o_vel_x,
    output logic signed [W-1:0] o_vel_y,
    output logic signed [W-1:0] o_angle,
    output logic signed [W-1:0] o_spin,
    output logic                o_saturated
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    typedef struct packed {
        t_word pos_x;
        t_word pos_y;
        t_word vel_x;
        t_word vel_y;
        t_word rot;
        t_word spin;
        t_word ta;
        t_word tb;
        t_word vx;
        t_word vy;
        t_word px;
        t_word py;
        t_word sc;
        t_word dt;
        t_word inv_m;
        t_word inv_i;
        t_word st_x;
        t_word st_y;
        t_word st_a;
        t_word prod;
    } t_srcs;

    localparam t_word W_MAX = {1'b0, {(W-1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(W-1){1'b0}}};

    function automatic t_word pick(t_src s, t_srcs v);
        t_word r;
        unique case (s)
            SRC_ZERO:  r = '0;
            SRC_POS_X: r = v.pos_x;
            SRC_POS_Y: r = v.pos_y;
            SRC_VEL_X: r = v.vel_x;
            SRC_VEL_Y: r = v.vel_y;
            SRC_ROT:   r = v.rot;
            SRC_SPIN:  r = v.spin;
            SRC_TA:    r = v.ta;
            SRC_TB:    r = v.tb;
            SRC_VX:    r = v.vx;
            SRC_VY:    r = v.vy;
            SRC_PX:    r = v.px;
            SRC_PY:    r = v.py;
            SRC_SC:    r = v.sc;
            SRC_DT:    r = v.dt;
            SRC_INV_M: r = v.inv_m;
            SRC_INV_I: r = v.inv_i;
            SRC_ST_X:  r = v.st_x;
            SRC_ST_Y:  r = v.st_y;
            SRC_ST_A:  r = v.st_a;
            SRC_PROD:  r = v.prod;
            default:   r = '0;
        endcase
        return r;
    endfunction

    // configuration
    logic [W-2:0] r_inv_mass;
    logic [W-2:0] r_inv_inertia;
    logic         r_is_static;
    t_word        r_start_x;
    t_word        r_start_y;
    t_word        r_start_angle;

    // body state and scratch
    t_word r_pos_x, r_pos_y, r_vel_x, r_vel_y, r_rot, r_spin;
    t_word r_ta, r_tb;

    // latched input beat
    logic [2:0]   r_cmd;
    t_word        r_vx, r_vy, r_px, r_py, r_sc;
    logic [W-2:0] r_dt;

    // sequencer
    t_state r_state, n_state;
    t_pc    r_pc, n_pc;
    logic   r_sat, n_sat;
    logic   r_out_valid, n_out_valid;
    logic   signed [2*W-1:0] r_prod;

    // output beat
    t_word r_o_pos_x, r_o_pos_y, r_o_vel_x, r_o_vel_y, r_o_rot, r_o_spin;
    logic  r_o_sat;

    t_uword                 word;
    t_srcs                  srcs;
    logic signed [2*W-1:0]  prod_full;
    logic signed [2*W-1:0]  prod_sh;
    logic                   prod_ovf;
    t_word                  prod_val;
    t_word                  mul_a, mul_b, add_x, add_y;
    logic signed [W+1:0]    sum;
    logic                   sum_ovf;
    t_word                  sum_val;
    logic                   step_sat;
    logic                   jump;
    logic                   accept;
    logic                   out_free;
    logic                   load_out;

    assign word     = ucode(r_pc);
    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign load_out = (r_state == ST_FIN) && out_free;

    assign prod_sh  = r_prod >>> FRAC_BITS;
    assign prod_ovf = !((&prod_sh[2*W-1:W-1]) || !(|prod_sh[2*W-1:W-1]));
    assign prod_val = prod_ovf ? (prod_sh[2*W-1] ? W_MIN : W_MAX) : prod_sh[W-1:0];

    always_comb begin
        srcs.pos_x = r_pos_x;
        srcs.pos_y = r_pos_y;
        srcs.vel_x = r_vel_x;
        srcs.vel_y = r_vel_y;
        srcs.rot   = r_rot;
        srcs.spin  = r_spin;
        srcs.ta    = r_ta;
        srcs.tb    = r_tb;
        srcs.vx    = r_vx;
        srcs.vy    = r_vy;
        srcs.px    = r_px;
        srcs.py    = r_py;
        srcs.sc    = r_sc;
        srcs.dt    = {1'b0, r_dt};
        srcs.inv_m = {1'b0, r_inv_mass};
        srcs.inv_i = {1'b0, r_inv_inertia};
        srcs.st_x  = r_start_x;
        srcs.st_y  = r_start_y;
        srcs.st_a  = r_start_angle;
        srcs.prod  = prod_val;
    end

    always_comb begin
        mul_a = pick(word.mul_a, srcs);
        mul_b = pick(word.mul_b, srcs);
        add_x = pick(word.add_x, srcs);
        add_y = pick(word.add_y, srcs);
        if (word.half) begin
            add_y = add_y >>> 1;
        end
    end

    assign prod_full = mul_a * mul_b;

    always_comb begin
        if (word.sub) begin
            sum = (W+2)'(add_x) - (W+2)'(add_y);
        end else begin
            sum = (W+2)'(add_x) + (W+2)'(add_y);
        end
        sum_ovf  = !((&sum[W+1:W-1]) || !(|sum[W+1:W-1]));
        sum_val  = sum_ovf ? (sum[W+1] ? W_MIN : W_MAX) : sum[W-1:0];
        step_sat = (word.dst != DST_NONE)
                   && (sum_ovf || ((word.add_y == SRC_PROD) && prod_ovf));
    end

    always_comb begin
        unique case (word.cond)
            COND_NEVER:  jump = 1'b0;
            COND_STATIC: jump = r_is_static;
            COND_HALF:   jump = (r_cmd == CMD_HALF_STEP);
            default:     jump = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_sat       = r_sat;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_RUN;
                    n_pc    = entry(i_command);
                    n_sat   = 1'b0;
                end
            end
            ST_RUN: begin
                n_sat = r_sat || step_sat;
                if (jump) begin
                    n_pc = word.target;
                end else if (word.last) begin
                    n_state = ST_FIN;
                end else begin
                    n_pc = t_pc'(r_pc + 1'b1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= EP_END;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass    <= '0;
            r_inv_inertia <= '0;
            r_is_static   <= 1'b0;
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_start_angle <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INV_MASS:    r_inv_mass    <= i_cfg_data[W-2:0];
                CFG_INV_INERTIA: r_inv_inertia <= i_cfg_data[W-2:0];
                CFG_IS_STATIC:   r_is_static   <= i_cfg_data[0];
                CFG_START_X:     r_start_x     <= i_cfg_data;
                CFG_START_Y:     r_start_y     <= i_cfg_data;
                CFG_START_ANGLE: r_start_angle <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_rot   <= '0;
            r_spin  <= '0;
        end else if (r_state == ST_RUN) begin
            unique case (word.dst)
                DST_POS_X: r_pos_x <= sum_val;
                DST_POS_Y: r_pos_y <= sum_val;
                DST_VEL_X: r_vel_x <= sum_val;
                DST_VEL_Y: r_vel_y <= sum_val;
                DST_ROT:   r_rot   <= sum_val;
                DST_SPIN:  r_spin  <= sum_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full;
        if (r_state == ST_RUN) begin
            if (word.dst == DST_TA) begin
                r_ta <= sum_val;
            end
            if (word.dst == DST_TB) begin
                r_tb <= sum_val;
            end
        end
        if (accept) begin
            r_cmd <= i_command;
            r_vx  <= i_vec_x;
            r_vy  <= i_vec_y;
            r_px  <= i_point_x;
            r_py  <= i_point_y;
            r_sc  <= i_scalar_value;
            r_dt  <= i_time_step;
        end
        if (load_out) begin
            r_o_pos_x <= r_pos_x;
            r_o_pos_y <= r_pos_y;
            r_o_vel_x <= r_vel_x;
            r_o_vel_y <= r_vel_y;
            r_o_rot   <= r_rot;
            r_o_spin  <= r_spin;
            r_o_sat   <= r_sat;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_o_pos_x;
    assign o_pos_y     = r_o_pos_y;
    assign o_vel_x     = r_o_vel_x;
    assign o_vel_y     = r_o_vel_y;
    assign o_angle     = r_o_rot;
    assign o_spin      = r_o_spin;
    assign o_saturated = r_o_sat;

endmodule

// File: rtl/core/rbi_checker.sv
// ----------------------------------------------------------------------------
// rbi_checker
// port level checks on the rigid body integrator, bound to the top level
// ----------------------------------------------------------------------------
module rbi_checker
    import rbi_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic signed [W-1:0] o_pos_x,
    input logic signed [W-1:0] o_pos_y,
    input logic signed [W-1:0] o_vel_x,
    input logic signed [W-1:0] o_vel_y,
    input logic signed [W-1:0] o_angle,
    input logic signed [W-1:0] o_spin,
    input logic                o_saturated
);

    // reset leaves the block ready and with no beat pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear handshake state");

    // one item at a time: busy right after an input beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while item in flight");

    a_out_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_pos_x) && $stable(o_pos_y)
            && $stable(o_vel_x) && $stable(o_vel_y) && $stable(o_angle)
            && $stable(o_spin) && $stable(o_saturated))
        else $error("result payload changed while stalled");

endmodule

bind rigid_body_integrator_top rbi_checker u_rbi_checker (.*);
